// File: hw/rtl/slp_pkg.sv
// Shared types, constants and helper functions for the series log/pow unit.
`default_nettype none
package slp_pkg;

    localparam int unsigned MAX_TERMS_DEF = 255;
    localparam int unsigned FRAC_BITS_DEF = 16;

    // Saturation bound for products and partial sums inside pow.
    localparam logic [63:0] LIM_Q = 64'h2000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEG_INF = 2'd1,
        ST_DOMAIN  = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_LN_TAYLOR  = 2'd0,
        OP_LN_FRAC    = 2'd1,
        OP_POW_TAYLOR = 2'd2,
        OP_POW_FRAC   = 2'd3
    } t_op;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    go;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV
    } t_alu_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOG_START,
        S_T_BASE,
        S_T_MUL,
        S_T_DIV,
        S_F_Z,
        S_F_Z2,
        S_F_SQ,
        S_F_NUM,
        S_F_DIV,
        S_F_FIN,
        S_LOG_END,
        S_P_T,
        S_E_MUL,
        S_E_DIV
    } t_state;

    function automatic logic [31:0] clip32(input logic signed [63:0] v);
        logic [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic over32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    // Denominators below one are forced to one.
    function automatic logic [63:0] den_clamp(input logic signed [63:0] v);
        logic [63:0] res;
        if (v < 64'sd1) begin
            res = 64'd1;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/slp_alu.sv
// Shared multi-cycle unit: 64x64 multiply in 32-bit pieces, 64/64 restoring divide.
`default_nettype none
module slp_alu (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slp_pkg::t_alu_req i_req,
    input  logic [63:0]      i_a,
    input  logic [63:0]      i_b,
    output logic             o_done,
    output logic [127:0]     o_res
);
    import slp_pkg::*;

    t_alu_state   r_state, n_state;
    logic [5:0]   r_cnt;
    logic [63:0]  r_a, r_b;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic [127:0] r_acc;
    logic [64:0]  r_rem;
    logic [63:0]  r_quo;
    logic         r_done;

    logic [31:0]  a_part, b_part;
    logic [127:0] pp_sh;
    logic [64:0]  rem_sh;
    logic         ge;

    assign a_part = r_cnt[0] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_cnt[1] ? r_b[63:32] : r_b[31:0];
    assign rem_sh = {r_rem[63:0], r_quo[63]};
    assign ge     = rem_sh >= {1'b0, r_b};

    always_comb begin
        case (r_sh)
            2'd0:    pp_sh = {64'd0, r_pp};
            2'd1:    pp_sh = {32'd0, r_pp, 32'd0};
            default: pp_sh = {r_pp, 64'd0};
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE: begin
                if (i_req.go) begin
                    n_state = (i_req.op == ALU_MUL) ? A_MUL : A_DIV;
                end
            end
            A_MUL: begin
                if (r_cnt == 6'd4) begin
                    n_state = A_IDLE;
                end
            end
            A_DIV: begin
                if (r_cnt == 6'd63) begin
                    n_state = A_IDLE;
                end
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_comb begin
        o_done = r_done;
        o_res  = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_cnt <= '0;
                    r_acc <= '0;
                    r_rem <= '0;
                    r_quo <= i_a;
                end
                A_MUL: begin
                    // register each partial product, then accumulate it from the register
                    if (r_cnt != 6'd4) begin
                        r_pp <= a_part * b_part;
                        r_sh <= 2'(r_cnt[0]) + 2'(r_cnt[1]);
                    end
                    if (r_cnt != 6'd0) begin
                        r_acc <= r_acc + pp_sh;
                    end
                    if (r_cnt == 6'd4) begin
                        r_done <= 1'b1;
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                A_DIV: begin
                    r_rem <= ge ? (rem_sh - {1'b0, r_b}) : rem_sh;
                    r_quo <= {r_quo[62:0], ge};
                    if (r_cnt == 6'd63) begin
                        r_done <= 1'b1;
                        r_acc  <= (r_b == 64'd0) ? 128'd0 : {64'd0, r_quo[62:0], ge};
                    end
                    r_cnt <= r_cnt + 6'd1;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/series_log_and_pow_unit.sv
// Top level of the series logarithm and power unit.
`default_nettype none
// Computes ln(x) as an n-term Taylor series or an n-level continued fraction,
// or x^y as an exponential series of y*ln(x) to the n-th power, in signed fixed point
// with FRAC_BITS fraction bits. Pulse start while busy is low to hand in a
// word; busy stays high until the result word appears on o_value/o_status
// for exactly one cycle with o_done high. The result cannot be held off, so
// capture it in that cycle. All multiplies and divides go through one shared
// unit. Zero or negative x returns its status word in the cycle right after
// the word is taken.
module series_log_and_pow_unit #(
    parameter int unsigned MAX_TERMS = slp_pkg::MAX_TERMS_DEF,
    parameter int unsigned FRAC_BITS = slp_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic [7:0]         i_terms,
    output logic               busy,
    output logic signed [31:0] o_value,
    output logic [1:0]         o_status,
    output logic               o_done
);
    import slp_pkg::*;

    localparam int unsigned KW = $clog2(MAX_TERMS + 2);
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

    t_state r_state, n_state;

    // captured word
    logic [1:0]         r_op;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [KW-1:0]      r_n;
    logic [KW-1:0]      r_k;

    // working registers
    logic [63:0]        r_base;
    logic signed [63:0] r_act;
    logic signed [63:0] r_sum;
    logic [63:0]        r_z;
    logic [63:0]        r_z2;
    logic signed [63:0] r_f;
    logic               r_big;
    logic [63:0]        r_t_mag;
    logic               r_t_neg;
    logic               r_p_neg;
    logic               r_sat;

    // shared unit handshake
    t_alu_req           r_req;
    logic [63:0]        r_alu_a, r_alu_b;
    logic               alu_done;
    logic [127:0]       alu_res;

    // result word
    logic [31:0]        r_value;
    t_status            r_status;
    logic               r_done;

    logic               accept;
    logic [KW-1:0]      n_terms;
    logic signed [63:0] x64, d64;
    logic [63:0]        d_mag;
    logic [63:0]        prod_q, quo;
    logic               mul_sat;
    logic signed [63:0] lg_fin;
    logic [63:0]        den_num, den_fin;
    logic signed [63:0] act_new, eta_raw;
    logic [63:0]        act_mag;
    logic signed [31:0] lg32;
    logic [63:0]        lg_mag, y_mag, p_mag;

    slp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_a     (r_alu_a),
        .i_b     (r_alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    assign accept  = start && !busy;
    assign x64     = 64'(r_x);
    assign d64     = x64 - ONE_Q;
    assign d_mag   = d64[63] ? (64'd0 - d64) : d64;
    assign prod_q  = alu_res[FRAC_BITS +: 64];
    assign quo     = alu_res[63:0];
    assign mul_sat = alu_res > {64'd0, LIM_Q};
    assign lg_fin  = r_big ? $signed(quo) : -$signed(quo);
    assign den_num = den_clamp($signed(((64'(r_k) << 1) - 64'd1) << FRAC_BITS) - r_f);
    assign den_fin = den_clamp(ONE_Q - $signed(quo));
    assign act_new = r_p_neg ? -$signed(quo) : $signed(quo);
    assign act_mag = act_new[63] ? (64'd0 - act_new) : act_new;
    assign eta_raw = r_sum + act_new;
    assign lg32    = $signed(clip32(r_sum));
    assign lg_mag  = lg32[31] ? (64'd0 - 64'(lg32)) : 64'(lg32);
    assign y_mag   = r_y[31] ? (64'd0 - 64'(r_y)) : 64'(r_y);
    assign p_mag   = mul_sat ? LIM_Q : prod_q;

    // zero maps to one, anything above the limit is clamped
    always_comb begin
        if (i_terms == 8'd0) begin
            n_terms = KW'(1);
        end else if (32'(i_terms) > MAX_TERMS) begin
            n_terms = KW'(MAX_TERMS);
        end else begin
            n_terms = KW'(i_terms);
        end
    end

    always_comb begin
        busy     = (r_state != S_IDLE);
        o_value  = r_value;
        o_status = r_status;
        o_done   = r_done;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_x > 32'sd0) begin
                    n_state = S_LOG_START;
                end
            end
            S_LOG_START: begin
                if (r_op[0]) begin
                    n_state = S_F_Z;
                end else if (x64 > ONE_Q) begin
                    n_state = S_T_BASE;
                end else begin
                    n_state = (r_n >= KW'(2)) ? S_T_MUL : S_LOG_END;
                end
            end
            S_T_BASE: if (alu_done) begin
                n_state = (r_n >= KW'(2)) ? S_T_MUL : S_LOG_END;
            end
            S_T_MUL: if (alu_done) begin
                n_state = S_T_DIV;
            end
            S_T_DIV: if (alu_done) begin
                n_state = (r_k < r_n) ? S_T_MUL : S_LOG_END;
            end
            S_F_Z: if (alu_done) begin
                n_state = S_F_Z2;
            end
            S_F_Z2: if (alu_done) begin
                n_state = (r_n > KW'(1)) ? S_F_SQ : S_F_FIN;
            end
            S_F_SQ: if (alu_done) begin
                n_state = S_F_NUM;
            end
            S_F_NUM: if (alu_done) begin
                n_state = S_F_DIV;
            end
            S_F_DIV: if (alu_done) begin
                n_state = (r_k > KW'(2)) ? S_F_SQ : S_F_FIN;
            end
            S_F_FIN: if (alu_done) begin
                n_state = S_LOG_END;
            end
            S_LOG_END: begin
                n_state = r_op[1] ? S_P_T : S_IDLE;
            end
            S_P_T: if (alu_done) begin
                n_state = S_E_MUL;
            end
            S_E_MUL: if (alu_done) begin
                n_state = S_E_DIV;
            end
            S_E_DIV: if (alu_done) begin
                n_state = (r_k < r_n) ? S_E_MUL : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_req    <= '{go: 1'b0, op: ALU_MUL};
            r_done   <= 1'b0;
            r_value  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_req.go <= 1'b0;
            r_done   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op  <= i_op;
                        r_x   <= i_x;
                        r_y   <= i_y;
                        r_n   <= n_terms;
                        r_sat <= 1'b0;
                        // non-positive x never reaches the series
                        if (i_x <= 32'sd0) begin
                            r_done <= 1'b1;
                            if (i_op[1] == 1'b0 && i_x == 32'sd0) begin
                                r_value  <= 32'h8000_0000;
                                r_status <= ST_NEG_INF;
                            end else begin
                                r_value  <= '0;
                                r_status <= ST_DOMAIN;
                            end
                        end
                    end
                end
                S_LOG_START: begin
                    r_k <= KW'(2);
                    if (r_op[0]) begin
                        r_big   <= !d64[63];
                        r_req   <= '{go: 1'b1, op: ALU_DIV};
                        r_alu_a <= d_mag << FRAC_BITS;
                        r_alu_b <= x64 + ONE_Q;
                    end else if (x64 > ONE_Q) begin
                        r_big   <= 1'b1;
                        r_req   <= '{go: 1'b1, op: ALU_DIV};
                        r_alu_a <= d_mag << FRAC_BITS;
                        r_alu_b <= x64;
                    end else begin
                        // at or below one: sum -u^i/i with u = 1 - x
                        r_big   <= 1'b0;
                        r_base  <= ONE_Q - x64;
                        r_act   <= ONE_Q - x64;
                        r_sum   <= x64 - ONE_Q;
                        r_req   <= '{go: (r_n >= KW'(2)), op: ALU_MUL};
                        r_alu_a <= ONE_Q - x64;
                        r_alu_b <= ONE_Q - x64;
                    end
                end
                S_T_BASE: if (alu_done) begin
                    r_base  <= quo;
                    r_act   <= quo;
                    r_sum   <= quo;
                    r_req   <= '{go: (r_n >= KW'(2)), op: ALU_MUL};
                    r_alu_a <= quo;
                    r_alu_b <= quo;
                end
                S_T_MUL: if (alu_done) begin
                    r_act   <= prod_q;
                    r_req   <= '{go: 1'b1, op: ALU_DIV};
                    r_alu_a <= prod_q;
                    r_alu_b <= 64'(r_k);
                end
                S_T_DIV: if (alu_done) begin
                    r_sum   <= r_big ? (r_sum + $signed(quo)) : (r_sum - $signed(quo));
                    r_k     <= r_k + KW'(1);
                    r_req   <= '{go: (r_k < r_n), op: ALU_MUL};
                    r_alu_a <= r_act;
                    r_alu_b <= r_base;
                end
                S_F_Z: if (alu_done) begin
                    r_z     <= quo;
                    r_req   <= '{go: 1'b1, op: ALU_MUL};
                    r_alu_a <= quo;
                    r_alu_b <= quo;
                end
                S_F_Z2: if (alu_done) begin
                    // evaluate bottom-up from the deepest level
                    r_z2 <= prod_q;
                    r_f  <= '0;
                    r_k  <= r_n;
                    if (r_n > KW'(1)) begin
                        r_req   <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a <= 64'(r_n - KW'(1));
                        r_alu_b <= 64'(r_n - KW'(1));
                    end else begin
                        r_req   <= '{go: 1'b1, op: ALU_DIV};
                        r_alu_a <= (r_z << 1) << FRAC_BITS;
                        r_alu_b <= ONE_Q;
                    end
                end
                S_F_SQ: if (alu_done) begin
                    r_req   <= '{go: 1'b1, op: ALU_MUL};
                    r_alu_a <= alu_res[63:0];
                    r_alu_b <= r_z2;
                end
                S_F_NUM: if (alu_done) begin
                    r_req   <= '{go: 1'b1, op: ALU_DIV};
                    r_alu_a <= alu_res[63:0] << FRAC_BITS;
                    r_alu_b <= den_num;
                end
                S_F_DIV: if (alu_done) begin
                    r_f <= $signed(quo);
                    r_k <= r_k - KW'(1);
                    if (r_k > KW'(2)) begin
                        r_req   <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a <= 64'(r_k - KW'(2));
                        r_alu_b <= 64'(r_k - KW'(2));
                    end else begin
                        r_req   <= '{go: 1'b1, op: ALU_DIV};
                        r_alu_a <= (r_z << 1) << FRAC_BITS;
                        r_alu_b <= den_fin;
                    end
                end
                S_F_FIN: if (alu_done) begin
                    r_sum <= lg_fin;
                end
                S_LOG_END: begin
                    if (r_op[1]) begin
                        // clamp the log to 32 bits, then form t = y * ln(x)
                        r_sat   <= r_sat | over32(r_sum);
                        r_t_neg <= r_y[31] != lg32[31];
                        r_req   <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a <= y_mag;
                        r_alu_b <= lg_mag;
                    end else begin
                        r_done   <= 1'b1;
                        r_value  <= clip32(r_sum);
                        r_status <= over32(r_sum) ? ST_SAT : ST_OK;
                    end
                end
                S_P_T: if (alu_done) begin
                    r_sat   <= r_sat | mul_sat;
                    r_t_mag <= p_mag;
                    r_act   <= ONE_Q;
                    r_sum   <= ONE_Q;
                    r_k     <= KW'(1);
                    r_p_neg <= r_t_neg;
                    r_req   <= '{go: 1'b1, op: ALU_MUL};
                    r_alu_a <= ONE_Q;
                    r_alu_b <= p_mag;
                end
                S_E_MUL: if (alu_done) begin
                    r_sat   <= r_sat | mul_sat;
                    r_req   <= '{go: 1'b1, op: ALU_DIV};
                    r_alu_a <= p_mag;
                    r_alu_b <= 64'(r_k);
                end
                S_E_DIV: if (alu_done) begin
                    logic signed [63:0] eta_new;
                    logic               sat_new;
                    sat_new = r_sat;
                    eta_new = eta_raw;
                    if (eta_raw > $signed(LIM_Q)) begin
                        eta_new = $signed(LIM_Q);
                        sat_new = 1'b1;
                    end else if (eta_raw < -$signed(LIM_Q)) begin
                        eta_new = -$signed(LIM_Q);
                        sat_new = 1'b1;
                    end
                    r_act   <= act_new;
                    r_sum   <= eta_new;
                    r_sat   <= sat_new;
                    r_k     <= r_k + KW'(1);
                    r_p_neg <= act_new[63] != r_t_neg;
                    if (r_k < r_n) begin
                        r_req   <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a <= act_mag;
                        r_alu_b <= r_t_mag;
                    end else begin
                        r_done   <= 1'b1;
                        r_value  <= clip32(eta_new);
                        r_status <= (sat_new || over32(eta_new)) ? ST_SAT : ST_OK;
                    end
                end
                default: begin
                    r_req.go <= 1'b0;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // a finished word always returns the unit to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    // an accepted word either finishes at once or starts the sequencer
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word dropped");

    a_domain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_DOMAIN) |-> (o_value == 32'sd0))
        else $error("domain error with nonzero value");

    a_neg_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NEG_INF) |-> (o_value == 32'h8000_0000))
        else $error("negative infinity with wrong value");
`endif

endmodule
`default_nettype wire
